### src/fitness_top_k_selector_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fitness top-K selector
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FITNESS_TOP_K_SELECTOR_UNIT_DEFINES_SVH
`define FITNESS_TOP_K_SELECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property checked at every clock edge outside reset.
`define FTKS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Same-cycle implication checked at every clock edge outside reset.
`define FTKS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FTKS_ASSERT(lbl, prop, msg)
`define FTKS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### src/ftks_pkg.sv
// ----------------------------------------------------------------------------
// Fitness top-K selector package
// Shared widths, payload types, cell types and the gene weight function.
// ----------------------------------------------------------------------------
package ftks_pkg;

    localparam int CHROM_W        = 30;
    localparam int MEMBER_W       = 5;
    localparam int FIT_W          = 14;
    localparam int RANK_W         = 3;
    localparam int GENE_COUNT     = 30;
    localparam int KEEP_COUNT_DEF = 5;
    localparam int WEIGHT_W       = 11;
    localparam int GROUP_SIZE     = 8;
    localparam int GROUP_COUNT    = (CHROM_W + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W          = GROUP_COUNT * GROUP_SIZE;
    localparam int SUM_W          = FIT_W + 1;

    localparam logic [FIT_W-1:0] TARGET_RESET = 14'd1977;
    localparam logic [FIT_W-1:0] FIT_MAX      = {FIT_W{1'b1}};

    localparam logic KIND_EVAL = 1'b0;
    localparam logic KIND_SLOT = 1'b1;

    typedef struct packed {
        logic [CHROM_W-1:0]  chromosome;
        logic [MEMBER_W-1:0] member_index;
        logic                start_generation;
        logic                end_generation;
    } t_in_item;

    typedef struct packed {
        logic                result_kind;
        logic [FIT_W-1:0]    fitness_value;
        logic                is_solution;
        logic [RANK_W-1:0]   rank;
        logic [MEMBER_W-1:0] result_member;
        logic                entry_valid;
        logic                last;
    } t_out_item;

    // Contents of one slot of the kept list.
    typedef struct packed {
        logic [FIT_W-1:0]    fit;
        logic [MEMBER_W-1:0] member;
        logic                valid;
    } t_cell_data;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } t_cell_ctrl;

    // Weight of gene g is (g+1)^2; genes past the chromosome or gene count weigh nothing.
    function automatic logic [WEIGHT_W-1:0] gene_weight(input int g);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        if (g < GENE_COUNT && g < CHROM_W) begin
            w = WEIGHT_W'((g + 1) * (g + 1));
        end
        return w;
    endfunction

endpackage

### src/fitness_top_k_selector_unit.sv
// ----------------------------------------------------------------------------
// Fitness top-K selector
// Scores chromosomes against a target and keeps the K best in a sorted chain.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  --------------------------
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (target value)
//
//  An input transaction passes through capture, group sums, distance to
//  target, then the ordered insert that also loads the evaluation result.
//  A generation-end transaction then lists each of the KEEP_COUNT slots in turn.
//  A new input transaction is taken once the previous one has left its last
//  result in the output register; that register holds while the output stalls.
//  Reset is synchronous and clears the list, solved flag and target to 1977.
//
`include "fitness_top_k_selector_unit_defines.svh"

module fitness_top_k_selector_unit import ftks_pkg::*; #(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [FIT_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(KEEP_COUNT + 1);
    localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

    // The sequencer walks one transaction through the evaluator and the chain.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_FIT  = 5'b00100,
        S_INS  = 5'b01000,
        S_LIST = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    logic              r_solved;
    logic [FIT_W-1:0]  r_target;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_do_rank;
    logic [FIT_W-1:0]  w_fit;
    logic [CNT_W-1:0]  w_keep_rank;
    logic [KEEP_COUNT-1:0] w_beat;
    logic [KEEP_COUNT-1:0] w_valid;
    t_cell_ctrl        w_ctrl;
    t_cell_data        w_new;
    t_cell_data        w_cell [KEEP_COUNT];

    assign o_in_ready  = (r_state == S_IDLE);
    // Target writes wait for the idle state, so no transaction being evaluated
    // sees its target change midway.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Exact solutions and every item after one in the same generation skip the list.
    assign w_do_rank = (w_fit != '0) && !r_solved;

    // Fitness pipeline runs from the captured chromosome.
    ftks_fitness u_fitness (
        .i_clk    (i_clk),
        .i_sum_en (r_state == S_SUM),
        .i_fit_en (r_state == S_FIT),
        .i_chrom  (r_item.chromosome),
        .i_target (r_target),
        .o_fit    (w_fit)
    );

    // Commands for the chain. The list is cleared as a starting item is captured,
    // so it is empty by the time that item reaches the insert step.
    always_comb begin
        w_ctrl.clear  = w_accept && i_in_data.start_generation;
        w_ctrl.insert = (r_state == S_INS) && w_out_free && w_do_rank;
        w_ctrl.rotate = (r_state == S_LIST) && w_out_free;
    end

    assign w_new.fit    = w_fit;
    assign w_new.member = r_item.member_index;
    assign w_new.valid  = 1'b1;

    // The chain: cell 0 is the best slot. An insert shifts later cells down by
    // one; a listing rotates the chain up so cell 0 shows each slot in turn and
    // the list is back in place after KEEP_COUNT steps.
    for (genvar c = 0; c < KEEP_COUNT; c++) begin : g_cell
        t_cell_data w_prev;
        logic       w_prev_beat;

        if (c == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_beat = 1'b0;
        end else begin : g_body
            assign w_prev      = w_cell[c-1];
            assign w_prev_beat = w_beat[c-1];
        end

        ftks_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new       (w_new),
            .i_prev      (w_prev),
            .i_prev_beat (w_prev_beat),
            .i_next      (w_cell[(c + 1) % KEEP_COUNT]),
            .o_data      (w_cell[c]),
            .o_beat      (w_beat[c])
        );

        assign w_valid[c] = w_cell[c].valid;
    end

    // Because the list is sorted with empty slots last, the beaten cells form a
    // tail; the slot taken is the number of cells not beaten.
    always_comb begin
        w_keep_rank = '0;
        for (int c = 0; c < KEEP_COUNT; c++) begin
            w_keep_rank = w_keep_rank + CNT_W'(!w_beat[c]);
        end
    end

    // Result selection: the evaluation result in the insert step, then one
    // slot result per listing step taken from the head of the chain.
    always_comb begin
        n_out = '0;
        if (r_state == S_LIST) begin
            n_out.result_kind   = KIND_SLOT;
            n_out.fitness_value = w_cell[0].fit;
            n_out.is_solution   = 1'b0;
            n_out.rank          = RANK_W'(r_slot);
            n_out.result_member = w_cell[0].member;
            n_out.entry_valid   = w_cell[0].valid;
            n_out.last          = (r_slot == SLOT_W'(KEEP_COUNT - 1));
        end else begin
            n_out.result_kind   = KIND_EVAL;
            n_out.fitness_value = w_fit;
            n_out.is_solution   = (w_fit == '0);
            n_out.rank          = w_do_rank ? RANK_W'(w_keep_rank) : RANK_W'(KEEP_COUNT);
            n_out.result_member = r_item.member_index;
            n_out.entry_valid   = 1'b0;
            n_out.last          = !r_item.end_generation;
        end
    end

    assign w_load_out = w_out_free && ((r_state == S_INS) || (r_state == S_LIST));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_FIT;
            end
            S_FIT: begin
                n_state = S_INS;
            end
            S_INS: begin
                if (w_out_free) begin
                    n_state = r_item.end_generation ? S_LIST : S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free && (r_slot == SLOT_W'(KEEP_COUNT - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_solved    <= 1'b0;
            r_target    <= TARGET_RESET;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
            if (w_accept && i_in_data.start_generation) begin
                r_solved <= 1'b0;
            end else if ((r_state == S_INS) && w_out_free && (w_fit == '0)) begin
                r_solved <= 1'b1;
            end
            if (r_state == S_INS) begin
                r_slot <= '0;
            end else if (w_ctrl.rotate) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Beaten cells must form a tail of the chain, or the insert would corrupt order.
    `FTKS_ASSERT_IMPL(a_beat_tail, r_state == S_INS,
        ((w_beat << 1) & ~w_beat) == '0, "beaten cells do not form a tail")
    // Between transactions the real entries fill the head of the list.
    `FTKS_ASSERT_IMPL(a_valid_prefix, r_state == S_IDLE,
        ((w_valid >> 1) & ~w_valid) == '0, "kept entries are not packed at the head")
    // The final listed slot is the last slot of the list.
    `FTKS_ASSERT_IMPL(a_last_slot,
        r_out_valid && (r_out.result_kind == KIND_SLOT) && r_out.last,
        r_out.rank == RANK_W'(KEEP_COUNT - 1), "final listed slot has wrong rank")
    // A solution is never placed in the list.
    `FTKS_ASSERT_IMPL(a_solution_unranked,
        r_out_valid && (r_out.result_kind == KIND_EVAL) && r_out.is_solution,
        r_out.rank == RANK_W'(KEEP_COUNT), "solution was ranked")

endmodule

### src/ftks_fitness.sv
// ----------------------------------------------------------------------------
// Fitness evaluator
// Two-stage weighted gene sum followed by the absolute distance to target.
// ----------------------------------------------------------------------------
module ftks_fitness import ftks_pkg::*; (
    input  logic               i_clk,
    input  logic               i_sum_en,
    input  logic               i_fit_en,
    input  logic [CHROM_W-1:0] i_chrom,
    input  logic [FIT_W-1:0]   i_target,
    output logic [FIT_W-1:0]   o_fit
);

    logic [PAD_W-1:0] w_chrom_pad;
    logic [FIT_W-1:0] n_psum [GROUP_COUNT];
    logic [FIT_W-1:0] r_psum [GROUP_COUNT];
    logic [SUM_W-1:0] w_total;
    logic [SUM_W-1:0] w_dist;
    logic [FIT_W-1:0] n_fit;
    logic [FIT_W-1:0] r_fit;

    assign w_chrom_pad = PAD_W'(i_chrom);

    // First stage: each group of genes is summed on its own.
    always_comb begin
        for (int gp = 0; gp < GROUP_COUNT; gp++) begin
            n_psum[gp] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (w_chrom_pad[gp * GROUP_SIZE + k]) begin
                    n_psum[gp] = n_psum[gp] + FIT_W'(gene_weight(gp * GROUP_SIZE + k));
                end
            end
        end
    end

    // Second stage: total of the groups and its distance to the target.
    always_comb begin
        w_total = '0;
        for (int gp = 0; gp < GROUP_COUNT; gp++) begin
            w_total = w_total + SUM_W'(r_psum[gp]);
        end
        if (w_total >= SUM_W'(i_target)) begin
            w_dist = w_total - SUM_W'(i_target);
        end else begin
            w_dist = SUM_W'(i_target) - w_total;
        end
        if (w_dist > SUM_W'(FIT_MAX)) begin
            n_fit = FIT_MAX;
        end else begin
            n_fit = w_dist[FIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_en) begin
            r_psum <= n_psum;
        end
        if (i_fit_en) begin
            r_fit <= n_fit;
        end
    end

    assign o_fit = r_fit;

endmodule

### src/ftks_cell.sv
// ----------------------------------------------------------------------------
// Kept list cell
// One slot of the sorted list: compares, shifts down on insert, rotates up.
// ----------------------------------------------------------------------------
module ftks_cell import ftks_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_data i_new,
    input  t_cell_data i_prev,
    input  logic       i_prev_beat,
    input  t_cell_data i_next,
    output t_cell_data o_data,
    output logic       o_beat
);

    t_cell_data r_data;
    t_cell_data n_data;

    // An empty slot is beaten by anything; ties leave the older entry ahead.
    assign o_beat = !r_data.valid || (i_new.fit < r_data.fit);

    always_comb begin
        n_data = r_data;
        priority if (i_ctrl.clear) begin
            n_data = '0;
        end else if (i_ctrl.insert) begin
            if (i_prev_beat) begin
                n_data = i_prev;
            end else if (o_beat) begin
                n_data = i_new;
            end
        end else if (i_ctrl.rotate) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule
